@@ hw/rtl/shc_pkg.sv @@
// ----------------------------------------------------------------------------
// shc_pkg
// Shared types and constants of the staged heater controller: phase codes,
// the fixed cooking profile table and the drive frequency set.
// ----------------------------------------------------------------------------
package shc_pkg;

    typedef enum logic [1:0] {
        PH_STANDBY = 2'd0,
        PH_COOKING = 2'd1,
        PH_WARMING = 2'd2
    } t_phase;

    // Stage ends are cumulative seconds from the start of cooking.
    typedef struct packed {
        logic [11:0] total;
        logic [11:0] end0;
        logic [11:0] end1;
        logic [11:0] end2;
        logic [11:0] end3;
        logic [7:0]  t1;
        logic [7:0]  t3;
        logic [7:0]  t4;
        logic [7:0]  keep;
    } t_profile;

    localparam t_profile PROF_TAB [4] = '{
        '{12'd300,  12'd60,  12'd120,  12'd240,  12'd300,  8'd110, 8'd110, 8'd110, 8'd110},
        '{12'd900,  12'd30,  12'd330,  12'd570,  12'd870,  8'd70,  8'd98,  8'd85,  8'd72},
        '{12'd3000, 12'd600, 12'd2400, 12'd2700, 12'd3000, 8'd60,  8'd95,  8'd80,  8'd70},
        '{12'd600,  12'd0,   12'd300,  12'd480,  12'd600,  8'd0,   8'd90,  8'd80,  8'd72}
    };

    localparam logic [15:0] FREQ_RESET = 16'd33000;
    localparam logic [15:0] FREQ_FULL  = 16'd26500;
    localparam logic [15:0] FREQ_MID   = 16'd30000;
    localparam logic [15:0] FREQ_LOW   = 16'd32000;

    localparam logic [15:0] Q_FATAL    = 16'd38400;   // 150.0 in Q8.8
    localparam logic [15:0] Q_MIN      = 16'd5120;    // 20.0
    localparam logic [15:0] Q_MAX      = 16'd51200;   // 200.0
    localparam logic signed [17:0] Q_ERR_HIGH = 18'sd3840;  // 15.0
    localparam logic signed [17:0] Q_ERR_LOW  = 18'sd1280;  // 5.0

    localparam logic [7:0] BOOST_TARGET = 8'd110;

    // Raise a requested setpoint below 30 to 30; one above 180 falls back to 115.
    function automatic logic [7:0] clamp_target(input logic [7:0] t);
        logic [7:0] v;
        v = (t < 8'd30) ? 8'd30 : t;
        if (v > 8'd180) begin
            v = 8'd115;
        end
        return v;
    endfunction

endpackage

@@ hw/rtl/shc_lowpass.sv @@
// ----------------------------------------------------------------------------
// shc_lowpass
// Q8.8 low-pass step: floor((9 * smoothed + 256 * bottom) / 10). The divide
// by ten is a reciprocal multiply that is exact for every 20-bit dividend.
// ----------------------------------------------------------------------------
module shc_lowpass
    import shc_pkg::*;
(
    input  logic [15:0] i_smoothed,
    input  logic [7:0]  i_bottom,
    output logic [15:0] o_smoothed
);

    localparam int          SHIFT = 24;
    localparam logic [20:0] RECIP = 21'd1677722;   // ceil(2^24 / 10)

    logic [19:0] sum;
    logic [40:0] prod;
    logic [40:0] quo;

    assign sum  = {1'b0, i_smoothed, 3'b000} + {4'b0000, i_smoothed}
                + {4'b0000, i_bottom, 8'h00};
    assign prod = {21'd0, sum} * {20'd0, RECIP};
    assign quo  = prod >> SHIFT;
    assign o_smoothed = quo[15:0];

endmodule

@@ hw/rtl/shc_secdiv.sv @@
// ----------------------------------------------------------------------------
// shc_secdiv
// Whole seconds from a tick count: floor(ticks / TICKS_PER_SECOND) by a
// reciprocal multiply, exact for any count below 2^DIFF_W.
// ----------------------------------------------------------------------------
module shc_secdiv
    import shc_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 1000,
    parameter int DIFF_W           = 22
)(
    input  logic [DIFF_W-1:0] i_ticks,
    output logic [11:0]       o_seconds
);

    localparam int          CLOG  = $clog2(TICKS_PER_SECOND);
    localparam int          SHIFT = DIFF_W + CLOG;
    localparam int          RW    = DIFF_W + 2;
    localparam logic [63:0] POW   = 64'd1 << SHIFT;
    localparam logic [63:0] RECIP64 = (POW + 64'(TICKS_PER_SECOND) - 64'd1)
                                    / 64'(TICKS_PER_SECOND);
    localparam logic [RW-1:0] RECIP = RECIP64[RW-1:0];

    logic [DIFF_W+RW-1:0] prod;
    logic [DIFF_W+RW-1:0] quo;

    assign prod = {{RW{1'b0}}, i_ticks} * {{DIFF_W{1'b0}}, RECIP};
    assign quo  = prod >> SHIFT;
    assign o_seconds = quo[11:0];

endmodule

@@ hw/rtl/staged_heater_thermal_controller.sv @@
// ----------------------------------------------------------------------------
// staged_heater_thermal_controller
// Staged induction-heater controller: profile start, overtemperature locks,
// stage scheduling, one-second filter gates and drive frequency choice.
//
//   channel  | handshake                 | payload
//   ---------+---------------------------+-----------------------------------
//   input    | i_in_valid / o_in_stall   | kind, now_ms, five temperatures
//   result   | o_out_valid / i_out_stall | heater_on, freq, phase, lock, secs
//   config   | i_cfg_we                  | i_cfg_data (profile select)
//
// One beat per cycle sustained while the result does not stall; an input beat
// passes the input register, then the result register. All state updates
// happen in the single pass between the two registers. A stalled result holds
// and the input register stalls only while it is full and the result cannot
// move. Synchronous active-low reset clears control and controller state; the
// stage end registers are only loaded by a start beat.
// ----------------------------------------------------------------------------
module staged_heater_thermal_controller
    import shc_pkg::*;
#(
    parameter int TICKS_PER_SECOND = 1000,
    parameter int GATE_TICKS       = 1000
)(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_kind,
    input  logic [31:0] i_now_ms,
    input  logic [7:0]  i_bottom_temp,
    input  logic [7:0]  i_side_temp,
    input  logic [7:0]  i_lid_temp,
    input  logic [7:0]  i_switch1_temp,
    input  logic [7:0]  i_switch2_temp,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_heater_on,
    output logic [15:0] o_drive_freq_hz,
    output logic [1:0]  o_cook_phase,
    output logic        o_protect_lock,
    output logic [11:0] o_remaining_sec
);

    localparam int TICK_W = $clog2(4096 * TICKS_PER_SECOND);

    // input register
    logic        r_in_valid;
    logic        r_kind;
    logic [31:0] r_now;
    logic [7:0]  r_bottom, r_side, r_lid, r_sw1, r_sw2;

    // configuration and controller state
    logic [1:0]        r_profile_sel;
    t_phase            r_phase, n_phase;
    logic              r_lock, n_lock;
    logic [15:0]       r_smoothed, n_smoothed;
    logic [7:0]        r_setpoint, n_setpoint;
    logic [15:0]       r_freq, n_freq;
    logic              r_drive, n_drive;
    logic [31:0]       r_start_time, n_start_time;
    logic [31:0]       r_pid_gate, n_pid_gate;
    logic [31:0]       r_boost_gate, n_boost_gate;
    logic [11:0]       r_total_sec, n_total_sec;
    logic [TICK_W-1:0] r_total_ticks, n_total_ticks;
    logic [TICK_W-1:0] r_end_ticks [4];
    logic [TICK_W-1:0] n_end_ticks [4];

    // result register
    logic        r_out_valid;
    logic        r_heater_on;
    logic [15:0] r_freq_out;
    logic [1:0]  r_phase_out;
    logic        r_lock_out;
    logic [11:0] r_remain_out;

    logic        advance;
    logic        fire;
    t_profile    prof;
    logic [15:0] filt;
    logic [31:0] elapsed;
    logic [3:0]  before_end;
    logic [31:0] out_diff;
    logic [11:0] out_secs;
    logic [11:0] remain;

    logic        lock_v, drv_v, do_temp, do_boost, pid_open, boost_open;
    logic [7:0]  tgt_req, sp;
    logic signed [17:0] err;

    assign advance    = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && advance;
    assign o_in_stall = r_in_valid && !advance;
    assign prof       = PROF_TAB[r_profile_sel];

    shc_lowpass u_lowpass (
        .i_smoothed (r_smoothed),
        .i_bottom   (r_bottom),
        .o_smoothed (filt)
    );

    assign elapsed    = r_now - r_start_time;
    assign pid_open   = (r_now - r_pid_gate) >= 32'(GATE_TICKS);
    assign boost_open = (r_now - r_boost_gate) >= 32'(GATE_TICKS);

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            before_end[i] = elapsed < 32'(r_end_ticks[i]);
        end
    end

    always_comb begin
        n_phase       = r_phase;
        n_lock        = r_lock;
        n_smoothed    = r_smoothed;
        n_setpoint    = r_setpoint;
        n_freq        = r_freq;
        n_drive       = r_drive;
        n_start_time  = r_start_time;
        n_pid_gate    = r_pid_gate;
        n_boost_gate  = r_boost_gate;
        n_total_sec   = r_total_sec;
        n_total_ticks = r_total_ticks;
        n_end_ticks   = r_end_ticks;
        lock_v        = r_lock;
        drv_v         = r_drive;
        do_temp       = 1'b0;
        do_boost      = 1'b0;
        tgt_req       = 8'd0;
        sp            = 8'd0;
        err           = '0;

        if (fire) begin
            if (r_kind) begin
                n_total_sec    = prof.total;
                n_total_ticks  = TICK_W'(prof.total) * TICK_W'(TICKS_PER_SECOND);
                n_start_time   = r_now;
                n_phase        = PH_COOKING;
                n_end_ticks[0] = TICK_W'(prof.end0) * TICK_W'(TICKS_PER_SECOND);
                n_end_ticks[1] = TICK_W'(prof.end1) * TICK_W'(TICKS_PER_SECOND);
                n_end_ticks[2] = TICK_W'(prof.end2) * TICK_W'(TICKS_PER_SECOND);
                n_end_ticks[3] = TICK_W'(prof.end3) * TICK_W'(TICKS_PER_SECOND);
                n_setpoint     = prof.t1;
                n_smoothed     = {prof.t1, 8'h00};
                n_lock         = 1'b0;
            end else if (r_smoothed > Q_FATAL || r_side > 8'd155 || r_lid > 8'd125) begin
                // fatal overtemperature: drop to standby and end the pass
                n_drive = 1'b0;
                n_lock  = 1'b1;
                n_phase = PH_STANDBY;
            end else begin
                if (r_bottom >= 8'd120) begin
                    drv_v  = 1'b0;
                    lock_v = 1'b1;
                end else begin
                    if (lock_v && r_bottom <= 8'd110) begin
                        lock_v = 1'b0;
                    end
                    if (r_sw1 > 8'd80 || r_sw2 > 8'd80) begin
                        drv_v  = 1'b0;
                        lock_v = 1'b1;
                    end else if (lock_v && r_sw1 < 8'd70 && r_sw2 < 8'd70) begin
                        lock_v = 1'b0;
                    end
                end

                unique case (r_phase)
                    PH_COOKING: begin
                        if (before_end[0]) begin
                            tgt_req = prof.t1;
                            do_temp = 1'b1;
                        end else if (before_end[1]) begin
                            do_boost = 1'b1;
                        end else if (before_end[2]) begin
                            tgt_req = prof.t3;
                            do_temp = 1'b1;
                        end else if (before_end[3]) begin
                            tgt_req = prof.t4;
                            do_temp = 1'b1;
                        end else begin
                            n_phase = PH_WARMING;
                            tgt_req = prof.keep;
                            do_temp = 1'b1;
                        end
                    end
                    PH_WARMING: begin
                        tgt_req = prof.keep;
                        do_temp = 1'b1;
                    end
                    default: begin
                        drv_v = 1'b0;
                    end
                endcase

                if (do_temp) begin
                    sp         = clamp_target(tgt_req);
                    n_setpoint = sp;
                    err = $signed({2'b00, sp, 8'h00}) - $signed({2'b00, filt});
                    if (lock_v) begin
                        drv_v = 1'b0;
                    end else if (pid_open) begin
                        n_pid_gate = r_now;
                        n_smoothed = filt;
                        if (filt < Q_MIN || filt > Q_MAX) begin
                            // filter out of range: leave the drive alone
                        end else if (r_bottom > 8'd150) begin
                            drv_v  = 1'b0;
                            lock_v = 1'b1;
                        end else if (r_bottom > 8'd130) begin
                            n_freq = FREQ_LOW;
                            drv_v  = 1'b1;
                        end else if ({1'b0, r_bottom} >= {1'b0, sp} + 9'd5) begin
                            drv_v = 1'b0;
                        end else if ({1'b0, r_bottom} + 9'd5 >= {1'b0, sp}) begin
                            // inside the hold band
                        end else if (err > Q_ERR_HIGH) begin
                            n_freq = FREQ_FULL;
                            drv_v  = 1'b1;
                        end else if (err > Q_ERR_LOW) begin
                            n_freq = FREQ_MID;
                            drv_v  = 1'b1;
                        end else begin
                            drv_v = 1'b0;
                        end
                    end
                end

                if (do_boost) begin
                    if (lock_v) begin
                        drv_v = 1'b0;
                    end else if (boost_open) begin
                        n_boost_gate = r_now;
                        n_smoothed   = filt;
                        n_setpoint   = clamp_target(BOOST_TARGET);
                        if (r_bottom >= 8'd125) begin
                            drv_v  = 1'b0;
                            lock_v = 1'b1;
                        end else if (r_bottom >= 8'd115) begin
                            n_freq = FREQ_LOW;
                            drv_v  = 1'b1;
                        end else begin
                            n_freq = FREQ_FULL;
                            drv_v  = 1'b1;
                        end
                    end
                end

                n_lock  = lock_v;
                n_drive = drv_v;
            end
        end
    end

    // seconds left, measured against the state this beat leaves behind
    assign out_diff = r_now - n_start_time;

    shc_secdiv #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .DIFF_W           (TICK_W)
    ) u_secdiv (
        .i_ticks   (out_diff[TICK_W-1:0]),
        .o_seconds (out_secs)
    );

    assign remain = (n_phase == PH_COOKING && out_diff < 32'(n_total_ticks))
                  ? (n_total_sec - out_secs) : 12'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_kind   <= i_kind;
            r_now    <= i_now_ms;
            r_bottom <= i_bottom_temp;
            r_side   <= i_side_temp;
            r_lid    <= i_lid_temp;
            r_sw1    <= i_switch1_temp;
            r_sw2    <= i_switch2_temp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_profile_sel <= 2'd0;
        end else if (i_cfg_we) begin
            r_profile_sel <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_STANDBY;
            r_lock        <= 1'b0;
            r_smoothed    <= 16'd0;
            r_setpoint    <= 8'd0;
            r_freq        <= FREQ_RESET;
            r_drive       <= 1'b0;
            r_start_time  <= 32'd0;
            r_pid_gate    <= 32'd0;
            r_boost_gate  <= 32'd0;
            r_total_sec   <= 12'd0;
            r_total_ticks <= '0;
        end else begin
            r_phase       <= n_phase;
            r_lock        <= n_lock;
            r_smoothed    <= n_smoothed;
            r_setpoint    <= n_setpoint;
            r_freq        <= n_freq;
            r_drive       <= n_drive;
            r_start_time  <= n_start_time;
            r_pid_gate    <= n_pid_gate;
            r_boost_gate  <= n_boost_gate;
            r_total_sec   <= n_total_sec;
            r_total_ticks <= n_total_ticks;
        end
    end

    always_ff @(posedge i_clk) begin
        r_end_ticks <= n_end_ticks;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_heater_on  <= n_drive;
            r_freq_out   <= n_freq;
            r_phase_out  <= n_phase;
            r_lock_out   <= n_lock;
            r_remain_out <= remain;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_heater_on     = r_heater_on;
    assign o_drive_freq_hz = r_freq_out;
    assign o_cook_phase    = r_phase_out;
    assign o_protect_lock  = r_lock_out;
    assign o_remaining_sec = r_remain_out;

endmodule
